[src/yrbi_pkg.sv]
// ----------------------------------------------------------------------------
// yrbi_pkg
// Shared types, register codes and helpers for the yaw-rate bias integrator.
// ----------------------------------------------------------------------------
package yrbi_pkg;

  localparam int RATE_W    = 32;
  localparam int HEAD_W    = 48;
  localparam int GAIN_W    = 32;
  localparam int CFG_IDX_W = 2;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POS_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEG_GAIN = 2'd2;

  localparam logic [RATE_W-1:0] DEADBAND_RST = 32'd2949;
  localparam logic [GAIN_W-1:0] GAIN_RST     = 32'd429497;

  // result queue
  localparam int OUTQ_DEPTH = 8;
  localparam int OUTQ_AW    = 3;

  typedef logic signed [RATE_W-1:0] rate_t;
  typedef logic signed [HEAD_W-1:0] head_t;

  localparam rate_t RATE_MAX = {1'b0, {(RATE_W-1){1'b1}}};
  localparam rate_t RATE_MIN = {1'b1, {(RATE_W-1){1'b0}}};
  localparam head_t HEAD_MAX = {1'b0, {(HEAD_W-1){1'b1}}};
  localparam head_t HEAD_MIN = {1'b1, {(HEAD_W-1){1'b0}}};

  // item entering the correction pipeline
  typedef struct packed {
    logic  valid;
    logic  rest;
    rate_t rate;
  } stage_t;

  // result beat, rate_out in the low bits
  typedef struct packed {
    rate_t bias_estimate;
    head_t heading;
    rate_t rate_out;
  } res_t;

  localparam int RES_W = $bits(res_t);

  // magnitude of a signed rate, most negative value maps to 2^31
  function automatic logic [RATE_W-1:0] rate_mag(input rate_t r);
    logic [RATE_W-1:0] u;
    u = r;
    return u[RATE_W-1] ? (~u + RATE_W'(1)) : u;
  endfunction

endpackage

[src/yrbi_cell.sv]
// ----------------------------------------------------------------------------
// yrbi_cell
// One rest-sample slot of the ring; takes its neighbor's sample on a shift.
// ----------------------------------------------------------------------------
module yrbi_cell import yrbi_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  shift,
  input  rate_t din,
  output rate_t dout
);

  always_ff @(posedge clk) begin
    if (rst) begin
      dout <= '0;
    end else if (shift) begin
      dout <= din;
    end
  end

endmodule

[src/yrbi_ring.sv]
// ----------------------------------------------------------------------------
// yrbi_ring
// Chain of rest-sample cells, running total and mean (bias) pipeline.
// ----------------------------------------------------------------------------
module yrbi_ring import yrbi_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  rate_t sample,
  output rate_t bias
);

  localparam int L     = $clog2(DEPTH);
  localparam int TW    = RATE_W + L;
  localparam int SHIFT = TW + L;
  localparam int PW    = 2 * TW + 1;
  localparam int P0_W  = 64;
  localparam int P1_W  = 33 + L;
  localparam int P2_W  = 32 + L;
  localparam int P3_W  = 2 * L + 1;

  // exact divide by DEPTH: multiply by ceil(2^SHIFT / DEPTH), keep high bits
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + 64'(DEPTH) - 64'd1) / 64'(DEPTH);
  localparam logic [TW:0]   RECIP_V  = RECIP[TW:0];
  localparam logic [31:0]   RECIP_LO = RECIP_V[31:0];
  localparam logic [L:0]    RECIP_HI = RECIP_V[TW:32];

  rate_t                  chain [DEPTH+1];
  logic signed [TW-1:0]   total;
  logic [TW-1:0]          tot_u;
  logic [TW-1:0]          tot_mag;
  logic [31:0]            mlo;
  logic [L-1:0]           mhi;
  logic [P0_W-1:0]        pp0;
  logic [P1_W-1:0]        pp1;
  logic [P2_W-1:0]        pp2;
  logic [P3_W-1:0]        pp3;
  logic                   pneg;
  logic [PW-1:0]          full;
  logic [31:0]            quot;

  assign chain[0] = sample;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    yrbi_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .shift(push),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  // oldest sample falls off the end of the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (push) begin
      total <= total - TW'(chain[DEPTH]) + TW'(sample);
    end
  end

  assign tot_u   = total;
  assign tot_mag = tot_u[TW-1] ? (~tot_u + TW'(1)) : tot_u;
  assign mlo     = tot_mag[31:0];
  assign mhi     = tot_mag[TW-1:32];

  always_ff @(posedge clk) begin
    if (rst) begin
      pp0  <= '0;
      pp1  <= '0;
      pp2  <= '0;
      pp3  <= '0;
      pneg <= 1'b0;
    end else begin
      pp0  <= P0_W'(mlo) * P0_W'(RECIP_LO);
      pp1  <= P1_W'(mlo) * P1_W'(RECIP_HI);
      pp2  <= P2_W'(mhi) * P2_W'(RECIP_LO);
      pp3  <= P3_W'(mhi) * P3_W'(RECIP_HI);
      pneg <= tot_u[TW-1];
    end
  end

  assign full = PW'(pp0) + (PW'(pp1) << 32) + (PW'(pp2) << 32) + (PW'(pp3) << 64);
  assign quot = full[SHIFT +: 32];

  // truncation toward zero: divide the magnitude, then restore the sign
  always_ff @(posedge clk) begin
    if (rst) begin
      bias <= '0;
    end else begin
      bias <= rate_t'(pneg ? (~quot + 32'd1) : quot);
    end
  end

endmodule

[src/yrbi_integ.sv]
// ----------------------------------------------------------------------------
// yrbi_integ
// Bias removal, deadband, trapezoid increment and saturating heading.
// ----------------------------------------------------------------------------
module yrbi_integ import yrbi_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  stage_t            a,
  input  rate_t             bias,
  input  logic [RATE_W-1:0] deadband,
  input  logic [GAIN_W-1:0] pos_gain,
  input  logic [GAIN_W-1:0] neg_gain,
  output logic              res_valid,
  output res_t              res
);

  localparam int SUM_W  = RATE_W + 1;
  localparam int PROD_W = SUM_W + GAIN_W;
  localparam int ACC_W  = HEAD_W + 2;

  logic signed [SUM_W-1:0] diff;
  rate_t                   sat_d;
  rate_t                   corr;
  rate_t                   prev_rate;

  logic                    b_valid;
  rate_t                   b_rate;
  rate_t                   b_prev;

  logic signed [SUM_W-1:0] sum;
  logic [SUM_W-1:0]        sum_u;
  logic [SUM_W-1:0]        smag;
  logic                    sum_pos;

  logic                    c_valid;
  logic [SUM_W-1:0]        c_mag;
  logic                    c_neg;
  logic [GAIN_W-1:0]       c_gain;
  rate_t                   c_rate;

  logic [PROD_W-1:0]       prod;

  logic                    d_valid;
  logic [SUM_W-1:0]        d_inc;
  logic                    d_neg;
  rate_t                   d_rate;
  rate_t                   d_bias;

  head_t                   yaw;
  logic signed [ACC_W-1:0] yext;
  logic signed [ACC_W-1:0] incx;
  logic signed [ACC_W-1:0] ysum;
  head_t                   ysat;

  // correction stage
  assign diff = SUM_W'(a.rate) - SUM_W'(bias);

  always_comb begin
    if (diff[SUM_W-1] != diff[SUM_W-2]) begin
      sat_d = diff[SUM_W-1] ? RATE_MIN : RATE_MAX;
    end else begin
      sat_d = diff[RATE_W-1:0];
    end
  end

  // rest samples always land below the deadband
  assign corr = (a.rest || (rate_mag(sat_d) < deadband)) ? '0 : sat_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      prev_rate <= '0;
    end else begin
      b_valid <= a.valid;
      if (a.valid) begin
        prev_rate <= corr;
      end
    end
    b_rate <= corr;
    b_prev <= prev_rate;
  end

  // trapezoid sum and gain select
  assign sum     = SUM_W'(b_rate) + SUM_W'(b_prev);
  assign sum_u   = sum;
  assign sum_pos = !sum_u[SUM_W-1] && (sum_u != '0);
  assign smag    = sum_u[SUM_W-1] ? (~sum_u + SUM_W'(1)) : sum_u;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= b_valid;
    end
    c_mag  <= smag;
    c_neg  <= sum_u[SUM_W-1];
    c_gain <= sum_pos ? pos_gain : neg_gain;
    c_rate <= b_rate;
  end

  // increment magnitude, truncated
  assign prod = PROD_W'(c_mag) * PROD_W'(c_gain);

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else begin
      d_valid <= c_valid;
    end
    d_inc  <= prod[PROD_W-1:32];
    d_neg  <= c_neg;
    d_rate <= c_rate;
    d_bias <= bias;
  end

  // saturating heading accumulator
  assign yext = ACC_W'(yaw);
  assign incx = $signed(ACC_W'(d_inc));
  assign ysum = d_neg ? (yext - incx) : (yext + incx);

  always_comb begin
    if (ysum > ACC_W'(HEAD_MAX)) begin
      ysat = HEAD_MAX;
    end else if (ysum < ACC_W'(HEAD_MIN)) begin
      ysat = HEAD_MIN;
    end else begin
      ysat = ysum[HEAD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      yaw <= '0;
    end else if (d_valid) begin
      yaw <= ysat;
    end
  end

  assign res_valid         = d_valid;
  assign res.rate_out      = d_rate;
  assign res.heading       = ysat;
  assign res.bias_estimate = d_bias;

  a_rate_deadband: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res.rate_out != '0)) |-> (rate_mag(res.rate_out) >= deadband))
    else $error("nonzero rate_out below deadband");

endmodule

[src/yrbi_outq.sv]
// ----------------------------------------------------------------------------
// yrbi_outq
// Small result queue between the pipeline and the master-side stream.
// ----------------------------------------------------------------------------
module yrbi_outq import yrbi_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  res_t             wdata,
  input  logic             rd,
  output logic             valid,
  output res_t             rdata
);

  localparam int AW = OUTQ_AW;

  res_t          mem [OUTQ_DEPTH];
  logic [AW-1:0] wp;
  logic [AW-1:0] rp;
  logic [AW:0]   cnt;

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr) begin
        wp <= wp + AW'(1);
      end
      if (rd) begin
        rp <= rp + AW'(1);
      end
      cnt <= cnt + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

  assign valid = (cnt != '0);
  assign rdata = mem[rp];

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr |-> ((cnt != (AW+1)'(OUTQ_DEPTH)) || rd))
    else $error("result queue overflow");

endmodule

[src/yaw_rate_bias_integrator_unit.sv]
// ----------------------------------------------------------------------------
// yaw_rate_bias_integrator_unit
// Beats pass the input register, correction, trapezoid, increment and queue.
// Throughput: one beat per cycle for moving samples while the queue has room;
// a rest sample holds off input until the ring mean refreshes the bias.
// Up to 8 beats may be outstanding, limited by the result queue.
// Reset (rst, synchronous): ring, bias, heading and queue cleared, registers
// back to their defaults.
// ----------------------------------------------------------------------------
module yaw_rate_bias_integrator_unit import yrbi_pkg::*; #(
  parameter int RING_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [RATE_W-1:0]    s_tdata,   // [31:0] rate_in
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [RES_W-1:0]     m_tdata,   // [31:0] rate_out, [79:32] heading,
                                          // [111:80] bias_estimate
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int CNT_W = OUTQ_AW + 1;

  logic [RATE_W-1:0] deadband;
  logic [GAIN_W-1:0] pos_gain;
  logic [GAIN_W-1:0] neg_gain;

  logic              s_acc;
  logic              m_acc;
  rate_t             in_rate;
  logic              in_rest;
  stage_t            a;
  logic              rest_hold;
  rate_t             bias;
  logic              res_valid;
  res_t              res;
  res_t              q_head;
  logic [CNT_W-1:0]  outstanding;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband <= DEADBAND_RST;
      pos_gain <= GAIN_RST;
      neg_gain <= GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DEADBAND: deadband <= cfg_data;
        REG_POS_GAIN: pos_gain <= cfg_data;
        REG_NEG_GAIN: neg_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_acc   = s_tvalid && s_tready;
  assign m_acc   = m_tvalid && m_tready;
  assign in_rate = rate_t'(s_tdata);
  assign in_rest = rate_mag(in_rate) < deadband;

  // hold off while a rest beat is in the input register or rest_hold is set, so the next one sees the new bias
  assign s_tready = (outstanding < CNT_W'(OUTQ_DEPTH)) && !(a.valid && a.rest) &&
                    !rest_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      a           <= '0;
      rest_hold   <= 1'b0;
      outstanding <= '0;
    end else begin
      a.valid     <= s_acc;
      a.rest      <= in_rest;
      a.rate      <= in_rate;
      rest_hold   <= a.valid && a.rest;
      outstanding <= outstanding + CNT_W'(s_acc) - CNT_W'(m_acc);
    end
  end

  yrbi_ring #(
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .rst   (rst),
    .push  (s_acc && in_rest),
    .sample(in_rate),
    .bias  (bias)
  );

  yrbi_integ u_integ (
    .clk      (clk),
    .rst      (rst),
    .a        (a),
    .bias     (bias),
    .deadband (deadband),
    .pos_gain (pos_gain),
    .neg_gain (neg_gain),
    .res_valid(res_valid),
    .res      (res)
  );

  yrbi_outq u_outq (
    .clk  (clk),
    .rst  (rst),
    .wr   (res_valid),
    .wdata(res),
    .rd   (m_acc),
    .valid(m_tvalid),
    .rdata(q_head)
  );

  assign m_tdata = q_head;

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    outstanding <= CNT_W'(OUTQ_DEPTH))
    else $error("outstanding beats exceed queue depth");

  a_rest_gap: assert property (@(posedge clk) disable iff (rst)
    (a.valid && a.rest) |-> !s_acc)
    else $error("beat taken while bias refresh pending");

  a_rest_hold: assert property (@(posedge clk) disable iff (rst)
    rest_hold |-> !s_acc)
    else $error("beat taken before bias refresh done");

  a_out_has_credit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (outstanding != '0))
    else $error("result offered with nothing outstanding");

endmodule
